// ===== sv/color_sum_pid_steering_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the color-sum PID steering block
// Each macro expands to a clocked concurrent assertion with an asynchronous
// active-low reset as its disable, or to nothing in a synthesis build.
// ----------------------------------------------------------------------------
`ifndef COLOR_SUM_PID_STEERING_ASSERT_SVH
`define COLOR_SUM_PID_STEERING_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CSTEER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CSTEER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CSTEER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define CSTEER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/csteer_pkg.sv =====
// ----------------------------------------------------------------------------
// csteer_pkg
// Shared types and constants of the color-sum PID steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package csteer_pkg;

	// Gain registers are unsigned fixed point, 24 bits wide.
	localparam int GAIN_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W     = 16;

	// Reset values of the proportional gains.
	localparam logic [GAIN_W-1:0] KP_STRAIGHT_RST = 24'd4588;
	localparam logic [GAIN_W-1:0] KP_CURVE_RST    = 24'd8520;

	// Output saturation limits.
	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_STRAIGHT = 3'd0,
		REG_KI_STRAIGHT = 3'd1,
		REG_KD_STRAIGHT = 3'd2,
		REG_KP_CURVE    = 3'd3,
		REG_KI_CURVE    = 3'd4,
		REG_KD_CURVE    = 3'd5
	} cfg_reg_t;

	// One set of gains.
	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gain_set_t;

	// Stage load enables from the pipeline control.
	typedef struct packed {
		logic load_s1;
		logic step_s2;
		logic load_s3;
		logic load_s4;
		logic load_out;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// ===== sv/csteer_cfg.sv =====
// ----------------------------------------------------------------------------
// csteer_cfg
// Gain register file: six write-only gain registers in two sets.
// ----------------------------------------------------------------------------
`default_nettype none

module csteer_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write_en,
	input  wire logic [csteer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csteer_pkg::GAIN_W-1:0]    cfg_data,
	output csteer_pkg::gain_set_t                gains_straight,
	output csteer_pkg::gain_set_t                gains_curve
);
	import csteer_pkg::*;

	gain_set_t straight_q;
	gain_set_t curve_q;
	cfg_reg_t  reg_sel;

	assign reg_sel = cfg_reg_t'(cfg_index);

	// Register writes; indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_q.kp <= KP_STRAIGHT_RST;
			straight_q.ki <= '0;
			straight_q.kd <= '0;
			curve_q.kp    <= KP_CURVE_RST;
			curve_q.ki    <= '0;
			curve_q.kd    <= '0;
		end else if (cfg_write_en) begin
			case (reg_sel)
				REG_KP_STRAIGHT: straight_q.kp <= cfg_data;
				REG_KI_STRAIGHT: straight_q.ki <= cfg_data;
				REG_KD_STRAIGHT: straight_q.kd <= cfg_data;
				REG_KP_CURVE:    curve_q.kp    <= cfg_data;
				REG_KI_CURVE:    curve_q.ki    <= cfg_data;
				REG_KD_CURVE:    curve_q.kd    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign gains_straight = straight_q;
	assign gains_curve    = curve_q;

endmodule

`default_nettype wire

// ===== sv/csteer_front.sv =====
// ----------------------------------------------------------------------------
// csteer_front
// Error front end: input register, error history and trapezoidal integral.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_sum_pid_steering_assert.svh"

module csteer_front #(
	parameter int SENSOR_BITS = 10,
	parameter int ACC_BITS    = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire csteer_pkg::pipe_ctl_t        ctl,
	input  wire logic                         command,
	input  wire logic [SENSOR_BITS-1:0]       red_sample,
	input  wire logic [SENSOR_BITS-1:0]       green_sample,
	input  wire logic [SENSOR_BITS-1:0]       blue_sample,
	input  wire logic [SENSOR_BITS+1:0]       target_level,
	input  wire logic                         gain_select,
	input  wire csteer_pkg::gain_set_t        gains_straight,
	input  wire csteer_pkg::gain_set_t        gains_curve,
	output logic signed [SENSOR_BITS+2:0]     e_s2,
	output logic signed [ACC_BITS-1:0]        esum_s2,
	output logic signed [SENSOR_BITS+3:0]     delta_s2,
	output csteer_pkg::gain_set_t             gains_s2
);
	import csteer_pkg::*;

	localparam int EW    = SENSOR_BITS + 3;
	localparam int DW    = SENSOR_BITS + 4;
	localparam int SUM_W = ACC_BITS + 2;
	localparam logic signed [SUM_W-1:0] ACC_MAX = {{3{1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN = {{3{1'b1}}, {(ACC_BITS-1){1'b0}}};

	logic [SENSOR_BITS+1:0]    sample_sum;
	logic signed [EW-1:0]      err_in;
	logic                      clear_s1;
	logic                      gsel_s1;
	logic signed [EW-1:0]      e_s1;
	logic signed [ACC_BITS-1:0] error_sum_q;
	logic signed [EW-1:0]      last_error_q;
	logic signed [SUM_W-1:0]   sum_wide;
	logic signed [ACC_BITS-1:0] esum_next;
	logic signed [DW-1:0]      delta;

	// Error against the target channel sum.
	assign sample_sum = (SENSOR_BITS+2)'(red_sample) + (SENSOR_BITS+2)'(green_sample)
		+ (SENSOR_BITS+2)'(blue_sample);
	assign err_in = $signed({1'b0, target_level}) - $signed({1'b0, sample_sum});

	// Input register.
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			clear_s1 <= command;
			gsel_s1  <= gain_select;
			e_s1     <= err_in;
		end
	end

	// Trapezoidal integral with saturation at the accumulator limits.
	assign sum_wide = SUM_W'(error_sum_q) + SUM_W'(e_s1) + SUM_W'(last_error_q);

	always_comb begin
		if (sum_wide > ACC_MAX) begin
			esum_next = ACC_MAX[ACC_BITS-1:0];
		end else if (sum_wide < ACC_MIN) begin
			esum_next = ACC_MIN[ACC_BITS-1:0];
		end else begin
			esum_next = sum_wide[ACC_BITS-1:0];
		end
	end

	assign delta = DW'(e_s1) - DW'(last_error_q);

	// Controller state advances once per item, in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (ctl.step_s2) begin
			if (clear_s1) begin
				error_sum_q  <= '0;
				last_error_q <= '0;
			end else begin
				error_sum_q  <= esum_next;
				last_error_q <= e_s1;
			end
		end
	end

	// Operands for the multipliers; a clear word feeds zeros so its result is zero.
	always_ff @(posedge clk) begin
		if (ctl.step_s2) begin
			gains_s2 <= gsel_s1 ? gains_curve : gains_straight;
			if (clear_s1) begin
				e_s2     <= '0;
				esum_s2  <= '0;
				delta_s2 <= '0;
			end else begin
				e_s2     <= e_s1;
				esum_s2  <= esum_next;
				delta_s2 <= delta;
			end
		end
	end

	`CSTEER_ASSERT_NXT(a_clear_zeroes_state, clk, arst_n, ctl.step_s2 && clear_s1,
		error_sum_q == '0 && last_error_q == '0, "clear word did not zero the state")
	`CSTEER_ASSERT_NXT(a_last_error_tracks, clk, arst_n, ctl.step_s2 && !clear_s1,
		last_error_q == $past(e_s1), "previous error not taken from the stepped word")

endmodule

`default_nettype wire

// ===== sv/csteer_mac.sv =====
// ----------------------------------------------------------------------------
// csteer_mac
// Gain multipliers and the sum of the three controller terms.
// ----------------------------------------------------------------------------
`default_nettype none

module csteer_mac #(
	parameter int SENSOR_BITS = 10,
	parameter int ACC_BITS    = 32
) (
	input  wire logic                                    clk,
	input  wire csteer_pkg::pipe_ctl_t                   ctl,
	input  wire logic signed [SENSOR_BITS+2:0]           e_s2,
	input  wire logic signed [ACC_BITS-1:0]              esum_s2,
	input  wire logic signed [SENSOR_BITS+3:0]           delta_s2,
	input  wire csteer_pkg::gain_set_t                   gains_s2,
	output logic signed [csteer_pkg::GAIN_W+ACC_BITS+1:0] total_s4
);
	import csteer_pkg::*;

	localparam int EW    = SENSOR_BITS + 3;
	localparam int DW    = SENSOR_BITS + 4;
	localparam int LO_W  = ACC_BITS / 2;
	localparam int HI_W  = ACC_BITS - LO_W;
	localparam int TOT_W = GAIN_W + ACC_BITS + 2;

	logic signed [HI_W-1:0]             esum_hi;
	logic [LO_W-1:0]                    esum_lo;
	logic signed [GAIN_W+EW:0]          pp_s3;
	logic signed [GAIN_W+DW:0]          pd_s3;
	logic signed [GAIN_W+HI_W:0]        pih_s3;
	logic [GAIN_W+LO_W-1:0]             pil_s3;
	logic signed [GAIN_W+LO_W:0]        pil_ext;

	// The integral product is split into two halves to keep each multiplier narrow.
	assign esum_hi = $signed(esum_s2[ACC_BITS-1:LO_W]);
	assign esum_lo = esum_s2[LO_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			pp_s3  <= $signed({1'b0, gains_s2.kp}) * e_s2;
			pd_s3  <= $signed({1'b0, gains_s2.kd}) * delta_s2;
			pih_s3 <= $signed({1'b0, gains_s2.ki}) * esum_hi;
			pil_s3 <= gains_s2.ki * esum_lo;
		end
	end

	assign pil_ext = $signed({1'b0, pil_s3});

	// Sum of the proportional, derivative and both integral partial products.
	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			total_s4 <= TOT_W'(pp_s3) + TOT_W'(pd_s3) + (TOT_W'(pih_s3) <<< LO_W)
				+ TOT_W'(pil_ext);
		end
	end

endmodule

`default_nettype wire

// ===== sv/csteer_sat.sv =====
// ----------------------------------------------------------------------------
// csteer_sat
// Fraction removal toward zero, 16-bit saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csteer_sat #(
	parameter int ACC_BITS  = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                         clk,
	input  wire csteer_pkg::pipe_ctl_t                        ctl,
	input  wire logic signed [csteer_pkg::GAIN_W+ACC_BITS+1:0] total_s4,
	output logic signed [csteer_pkg::OUT_W-1:0]               steering_q
);
	import csteer_pkg::*;

	localparam int TOT_W = GAIN_W + ACC_BITS + 2;
	localparam logic signed [TOT_W-1:0] ROUND_IN = {{(TOT_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic signed [TOT_W-1:0] SAT_MAX  = TOT_W'(OUT_MAX);
	localparam logic signed [TOT_W-1:0] SAT_MIN  = TOT_W'(OUT_MIN);

	logic signed [TOT_W-1:0] biased;
	logic signed [TOT_W-1:0] quo;

	// A negative total is biased up before the arithmetic shift so it truncates toward zero.
	assign biased = total_s4 + (total_s4[TOT_W-1] ? ROUND_IN : '0);
	assign quo    = biased >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (quo > SAT_MAX) begin
				steering_q <= OUT_MAX;
			end else if (quo < SAT_MIN) begin
				steering_q <= OUT_MIN;
			end else begin
				steering_q <= quo[OUT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/color_sum_pid_steering.sv =====
// ----------------------------------------------------------------------------
// color_sum_pid_steering
// PID steering from the sum of three color sensor channels.
// ----------------------------------------------------------------------------
// Each input word gives one steering word. The block takes a new word in every
// cycle and passes it through a pipeline of an input register, the integral
// update, the gain multipliers, the term sum and the saturating output register.
// The integral and previous error are updated as a word leaves the input
// register, so words are handled strictly in order. A stalled output only holds
// the input back once all five stages are full. The user must write gain
// registers through the configuration port only while no word is in flight; the
// block does not enforce it. A write to an index past the last gain is dropped.
`default_nettype none

`include "color_sum_pid_steering_assert.svh"

module color_sum_pid_steering #(
	parameter int SENSOR_BITS = 10,
	parameter int FRAC_BITS   = 16,
	parameter int ACC_BITS    = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write_en,
	input  wire logic [csteer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csteer_pkg::GAIN_W-1:0]    cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             command,
	input  wire logic [SENSOR_BITS-1:0]           red_sample,
	input  wire logic [SENSOR_BITS-1:0]           green_sample,
	input  wire logic [SENSOR_BITS-1:0]           blue_sample,
	input  wire logic [SENSOR_BITS+1:0]           target_level,
	input  wire logic                             gain_select,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [csteer_pkg::OUT_W-1:0]   steering
);
	import csteer_pkg::*;

	gain_set_t gains_straight;
	gain_set_t gains_curve;
	gain_set_t gains_s2;
	pipe_ctl_t ctl;

	logic signed [SENSOR_BITS+2:0]     e_s2;
	logic signed [ACC_BITS-1:0]        esum_s2;
	logic signed [SENSOR_BITS+3:0]     delta_s2;
	logic signed [GAIN_W+ACC_BITS+1:0] total_s4;

	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;

	// A stage can take a word when it is empty or its word moves on this cycle.
	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s4  = !valid_s4 || rdy_out;
	assign rdy_s3  = !valid_s3 || rdy_s4;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;

	assign ctl.load_s1  = in_valid && rdy_s1;
	assign ctl.step_s2  = valid_s1 && rdy_s2;
	assign ctl.load_s3  = valid_s2 && rdy_s3;
	assign ctl.load_s4  = valid_s3 && rdy_s4;
	assign ctl.load_out = valid_s4 && rdy_out;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s4;
			end
		end
	end

	assign in_stall  = !rdy_s1;
	assign out_valid = out_valid_q;

	csteer_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.gains_straight (gains_straight),
		.gains_curve    (gains_curve)
	);

	csteer_front #(
		.SENSOR_BITS (SENSOR_BITS),
		.ACC_BITS    (ACC_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.command        (command),
		.red_sample     (red_sample),
		.green_sample   (green_sample),
		.blue_sample    (blue_sample),
		.target_level   (target_level),
		.gain_select    (gain_select),
		.gains_straight (gains_straight),
		.gains_curve    (gains_curve),
		.e_s2           (e_s2),
		.esum_s2        (esum_s2),
		.delta_s2       (delta_s2),
		.gains_s2       (gains_s2)
	);

	csteer_mac #(
		.SENSOR_BITS (SENSOR_BITS),
		.ACC_BITS    (ACC_BITS)
	) u_mac (
		.clk      (clk),
		.ctl      (ctl),
		.e_s2     (e_s2),
		.esum_s2  (esum_s2),
		.delta_s2 (delta_s2),
		.gains_s2 (gains_s2),
		.total_s4 (total_s4)
	);

	csteer_sat #(
		.ACC_BITS  (ACC_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_sat (
		.clk        (clk),
		.ctl        (ctl),
		.total_s4   (total_s4),
		.steering_q (steering)
	);

	`CSTEER_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, in_stall,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_valid_q,
		"input stalled while the pipeline has room")
	`CSTEER_ASSERT_NXT(a_last_stage_drains, clk, arst_n, valid_s4 && !out_stall,
		out_valid_q, "word in the last stage did not reach the output")

endmodule

`default_nettype wire

// ===== tb/tb_color_sum_pid_steering.sv =====
// ----------------------------------------------------------------------------
// tb_color_sum_pid_steering
// Self-checking bench for the color-sum PID steering block. A short table of
// directed words and gain writes comes first, then random phases with fresh
// gains each. An in-bench predictor computes every steering word, and the
// output side checks each accepted word against the oldest one due.
// Both sides idle at random; one phase holds the output off long enough to
// fill the pipeline.
// ----------------------------------------------------------------------------
module tb_color_sum_pid_steering;
	timeunit 1ns;
	timeprecision 1ps;

	import csteer_pkg::*;

	localparam logic CMD_STEP     = 1'b0;
	localparam logic CMD_CLEAR    = 1'b1;
	localparam logic SET_STRAIGHT = 1'b0;
	localparam logic SET_CURVE    = 1'b1;

	// Indexes past the last gain register; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 3'd7;

	localparam logic [9:0]  SAMPLE_MAX = 10'h3FF;
	localparam logic [11:0] TARGET_MAX = 12'hFFF;
	localparam longint INTEG_HI  = 64'sd2147483647;
	localparam longint INTEG_LO  = -64'sd2147483648;
	localparam int     FRAC_BITS = 16;

	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 80;
	localparam int END_LIMIT    = 5000;
	localparam int RAND_PHASES  = 7;
	localparam int PHASE_WORDS  = 95;

	typedef enum {ROW_WORD, ROW_GAIN} row_kind_t;

	// One row of the directed table: either an input word or a gain write.
	typedef struct {
		row_kind_t               kind;
		logic                    cmd;
		logic [9:0]              red;
		logic [9:0]              green;
		logic [9:0]              blue;
		logic [11:0]             target;
		logic                    gsel;
		logic [CFG_IDX_W-1:0]    idx;
		logic [GAIN_W-1:0]       val;
		bit                      typed;
		logic signed [OUT_W-1:0] typed_val;
	} vector_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [GAIN_W-1:0]       cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    command;
	logic [9:0]              red_sample;
	logic [9:0]              green_sample;
	logic [9:0]              blue_sample;
	logic [11:0]             target_level;
	logic                    gain_select;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] steering;

	// Predictor state: both gain sets, the integral and the previous error.
	gain_set_t gain_bank [2];
	longint    integ_sum;
	longint    prev_error;

	logic signed [OUT_W-1:0] due_steering [$];
	vector_t                 vectors [$];
	int                      fault_count;
	bit                      calm;
	bit                      hold_request;

	color_sum_pid_steering u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.red_sample   (red_sample),
		.green_sample (green_sample),
		.blue_sample  (blue_sample),
		.target_level (target_level),
		.gain_select  (gain_select),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.steering     (steering)
	);

	always #5 clk = ~clk;

	// The run must not hang; this bounds it well past the slowest clean run.
	initial begin
		#30_000_000;
		$display("tb_color_sum_pid_steering: errors");
		$finish;
	end

	// Steering for one word, advancing the integral and error history.
	// Products stay below 2^56 at these widths, so the longint sum cannot overflow.
	function automatic logic signed [OUT_W-1:0] next_steering(input logic cmd,
			input logic [9:0] red, input logic [9:0] green, input logic [9:0] blue,
			input logic [11:0] target, input logic gsel);
		longint    err;
		longint    diff;
		longint    total;
		longint    mag;
		gain_set_t g;
		if (cmd == CMD_CLEAR) begin
			integ_sum = 0;
			prev_error = 0;
			return '0;
		end
		err = longint'(target) - longint'(red) - longint'(green) - longint'(blue);
		g = gain_bank[gsel];
		integ_sum = integ_sum + err + prev_error;
		if (integ_sum > INTEG_HI)
			integ_sum = INTEG_HI;
		else if (integ_sum < INTEG_LO)
			integ_sum = INTEG_LO;
		diff = err - prev_error;
		prev_error = err;
		total = longint'(g.kp) * err + longint'(g.ki) * integ_sum + longint'(g.kd) * diff;
		// Shift the magnitude so the result truncates toward zero.
		if (total < 0) begin
			mag = (-total) >> FRAC_BITS;
			if (mag > 32768)
				return OUT_MIN;
			return OUT_W'(-mag);
		end
		mag = total >> FRAC_BITS;
		if (mag > 32767)
			return OUT_MAX;
		return OUT_W'(mag);
	endfunction

	function automatic void note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", what);
	endfunction

	// Idle length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Gain for a random phase: all maximum first, all zero last, else a mix.
	function automatic logic [GAIN_W-1:0] gain_for(input int ph, input int small_max);
		logic [GAIN_W-1:0] v;
		if (ph == 0)
			return '1;
		if (ph == RAND_PHASES - 1)
			return '0;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2, 3: v = GAIN_W'($urandom);
			default: v = GAIN_W'($urandom_range(0, small_max));
		endcase
		return v;
	endfunction

	function automatic void add_word(input logic cmd, input logic [9:0] red,
			input logic [9:0] green, input logic [9:0] blue, input logic [11:0] target,
			input logic gsel, input bit typed, input logic signed [OUT_W-1:0] typed_val);
		vector_t row;
		row.kind = ROW_WORD;
		row.cmd = cmd;
		row.red = red;
		row.green = green;
		row.blue = blue;
		row.target = target;
		row.gsel = gsel;
		row.typed = typed;
		row.typed_val = typed_val;
		vectors.push_back(row);
	endfunction

	function automatic void add_gain(input logic [CFG_IDX_W-1:0] idx,
			input logic [GAIN_W-1:0] val);
		vector_t row;
		row.kind = ROW_GAIN;
		row.idx = idx;
		row.val = val;
		vectors.push_back(row);
	endfunction

	// Gain write while idle; the enable is then dropped so writes never abut.
	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_KP_STRAIGHT: gain_bank[SET_STRAIGHT].kp = val;
			REG_KI_STRAIGHT: gain_bank[SET_STRAIGHT].ki = val;
			REG_KD_STRAIGHT: gain_bank[SET_STRAIGHT].kd = val;
			REG_KP_CURVE:    gain_bank[SET_CURVE].kp = val;
			REG_KI_CURVE:    gain_bank[SET_CURVE].ki = val;
			REG_KD_CURVE:    gain_bank[SET_CURVE].kd = val;
			default: ;
		endcase
	endtask

	// Offer one word, wait for it to be taken, then queue its steering.
	task automatic send_word(input logic cmd, input logic [9:0] red, input logic [9:0] green,
			input logic [9:0] blue, input logic [11:0] target, input logic gsel,
			input bit typed, input logic signed [OUT_W-1:0] typed_val);
		logic signed [OUT_W-1:0] want;
		int gap;
		command <= cmd;
		red_sample <= red;
		green_sample <= green;
		blue_sample <= blue;
		target_level <= target;
		gain_select <= gsel;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = next_steering(cmd, red, green, blue, target, gsel);
		if (typed)
			want = typed_val;
		due_steering.push_back(want);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let every word in flight come out before touching the gains.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_steering.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output side: check accepted words and stall at random.
	initial begin : receiver
		int                      stall_left;
		bit                      hold_served;
		logic signed [OUT_W-1:0] want;
		out_stall = 1'b0;
		stall_left = 0;
		hold_served = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (due_steering.size() == 0) begin
					note_fault($sformatf("steering word %0d with none outstanding", steering));
				end else begin
					want = due_steering.pop_front();
					if (steering !== want)
						note_fault($sformatf("steering mismatch: expected %0d, got %0d",
							want, steering));
				end
			end
			// The long hold is counted here while the sender keeps offering.
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Input side: directed table, then random phases.
	initial begin : stimulus
		int ph;
		int n;
		int sel;
		int r;
		int g;
		int b;
		int t;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_STEP;
		red_sample = '0;
		green_sample = '0;
		blue_sample = '0;
		target_level = '0;
		gain_select = SET_STRAIGHT;
		calm = 1'b0;
		hold_request = 1'b0;
		fault_count = 0;
		integ_sum = 0;
		prev_error = 0;
		gain_bank[SET_STRAIGHT] = '{kp: KP_STRAIGHT_RST, ki: '0, kd: '0};
		gain_bank[SET_CURVE] = '{kp: KP_CURVE_RST, ki: '0, kd: '0};

		// Reset gains first, then each gain alone at full scale.
		add_word(CMD_STEP, '0, '0, '0, '0, SET_STRAIGHT, 1'b1, '0);
		add_word(CMD_STEP, '0, '0, '0, TARGET_MAX, SET_CURVE, 1'b0, '0);
		add_word(CMD_STEP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, SET_STRAIGHT, 1'b0, '0);
		add_word(CMD_STEP, 10'd1023, 10'd0, 10'd512, 12'd3069, SET_CURVE, 1'b0, '0);
		add_word(CMD_CLEAR, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, TARGET_MAX, SET_CURVE,
			1'b1, '0);
		add_gain(REG_KP_STRAIGHT, '1);
		add_word(CMD_STEP, '0, '0, '0, TARGET_MAX, SET_STRAIGHT, 1'b1, OUT_MAX);
		add_word(CMD_STEP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, SET_STRAIGHT, 1'b1, OUT_MIN);
		add_word(CMD_CLEAR, '0, '0, '0, '0, SET_STRAIGHT, 1'b1, '0);
		add_gain(REG_KP_STRAIGHT, '0);
		add_gain(REG_KI_STRAIGHT, '1);
		add_word(CMD_STEP, '0, '0, '0, TARGET_MAX, SET_STRAIGHT, 1'b1, OUT_MAX);
		add_word(CMD_STEP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, SET_STRAIGHT, 1'b0, '0);
		add_word(CMD_CLEAR, '0, '0, '0, '0, SET_STRAIGHT, 1'b1, '0);
		add_gain(REG_KI_STRAIGHT, '0);
		add_gain(REG_KD_STRAIGHT, '1);
		add_word(CMD_STEP, '0, '0, '0, TARGET_MAX, SET_STRAIGHT, 1'b1, OUT_MAX);
		add_word(CMD_STEP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, SET_STRAIGHT, 1'b1, OUT_MIN);
		// Same error twice: the derivative term vanishes.
		add_word(CMD_STEP, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, SET_STRAIGHT, 1'b1, '0);
		// Unity and one-half proportional gain show the truncation toward zero.
		add_gain(REG_KP_CURVE, 24'd65536);
		add_word(CMD_STEP, '0, '0, '0, TARGET_MAX, SET_CURVE, 1'b1, 16'sd4095);
		add_word(CMD_STEP, 10'd1, '0, '0, '0, SET_CURVE, 1'b1, -16'sd1);
		add_gain(REG_KP_CURVE, 24'd32768);
		add_word(CMD_STEP, 10'd1, '0, '0, '0, SET_CURVE, 1'b1, '0);
		add_gain(REG_PAST_LAST, '1);
		add_gain(REG_TOP_INDEX, '1);
		add_word(CMD_STEP, 10'd3, '0, '0, '0, SET_CURVE, 1'b1, -16'sd1);
		add_word(CMD_STEP, 10'd5, 10'd5, 10'd5, 12'd15, SET_STRAIGHT, 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (vectors[i]) begin
			if (vectors[i].kind == ROW_GAIN) begin
				settle();
				write_gain(vectors[i].idx, vectors[i].val);
			end else begin
				send_word(vectors[i].cmd, vectors[i].red, vectors[i].green, vectors[i].blue,
					vectors[i].target, vectors[i].gsel, vectors[i].typed,
					vectors[i].typed_val);
			end
		end

		// Random phases, each with its own gains.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			calm = (ph == 1 || ph == 4);
			write_gain(REG_KP_STRAIGHT, gain_for(ph, 1 << 17));
			write_gain(REG_KI_STRAIGHT, gain_for(ph, 1 << 11));
			write_gain(REG_KD_STRAIGHT, gain_for(ph, 1 << 16));
			write_gain(REG_KP_CURVE, gain_for(ph, 1 << 17));
			write_gain(REG_KI_CURVE, gain_for(ph, 1 << 11));
			write_gain(REG_KD_CURVE, gain_for(ph, 1 << 16));
			write_gain(REG_PAST_LAST, GAIN_W'($urandom));
			write_gain(REG_TOP_INDEX, GAIN_W'($urandom));
			if (ph == 1)
				hold_request <= 1'b1;
			for (n = 0; n < PHASE_WORDS; n++) begin
				sel = $urandom_range(0, 99);
				r = $urandom_range(0, 1023);
				g = $urandom_range(0, 1023);
				b = $urandom_range(0, 1023);
				t = $urandom_range(0, 4095);
				if (sel < 12) begin
					// Fields pinned at their ends.
					r = $urandom_range(0, 1) ? 1023 : 0;
					g = $urandom_range(0, 1) ? 1023 : 0;
					b = $urandom_range(0, 1) ? 1023 : 0;
					t = $urandom_range(0, 1) ? 4095 : 0;
				end else if (sel < 88) begin
					// Tracking: the target sits near the measured sum.
					t = r + g + b + int'($urandom_range(0, 600)) - 300;
					if (t < 0)
						t = 0;
					if (t > 4095)
						t = 4095;
				end
				send_word((sel < 5) ? CMD_CLEAR : CMD_STEP, 10'(r), 10'(g), 10'(b), 12'(t),
					1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		// Wait out the last words, then watch for strays.
		in_valid <= 1'b0;
		for (n = 0; n < END_LIMIT && due_steering.size() != 0; n++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && due_steering.size() == 0)
			$display("tb_color_sum_pid_steering: clean");
		else
			$display("tb_color_sum_pid_steering: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/csteer_pkg.sv
sv/csteer_cfg.sv
sv/csteer_front.sv
sv/csteer_mac.sv
sv/csteer_sat.sv
sv/color_sum_pid_steering.sv
tb/tb_color_sum_pid_steering.sv
